FILE: rtl/rtlpm_pkg.sv
// Shared types, constants and helpers for the longest-prefix-match route table.
// Used by rtlpm_cell and route_table_longest_prefix_match; depends on nothing.

package rtlpm_pkg;

  localparam int unsigned RouteEntries = 64;
  localparam int unsigned AddrW        = 32;
  localparam int unsigned LenW         = 6;
  localparam int unsigned IfW          = 8;
  localparam int unsigned RmvW         = 7;
  localparam int unsigned MaxLen       = 32;
  localparam int unsigned RmvMax       = 127;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // One stored route
  typedef struct packed {
    logic [AddrW-1:0] prefix;
    logic [LenW-1:0]  len;
    logic [IfW-1:0]   ifx;
    logic [AddrW-1:0] hop;
  } route_t;

  // Best match carried along the chain by a lookup transaction
  typedef struct packed {
    logic             found;
    logic [LenW-1:0]  len;
    logic [IfW-1:0]   ifx;
    logic [AddrW-1:0] hop;
  } acc_t;

  // Operation control broadcast from the sequencer to every cell
  typedef struct packed {
    logic             is_del;
    logic [AddrW-1:0] key;
    logic [LenW-1:0]  del_len;
    logic             sort_en;
    logic             phase;
  } ctrl_t;

  // Saturate a prefix length to the address width
  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] l);
    return (l > LenW'(MaxLen)) ? LenW'(MaxLen) : l;
  endfunction

  // Mask of the top l address bits; l is at most the address width
  function automatic logic [AddrW-1:0] prefix_mask(input logic [LenW-1:0] l);
    return ~({AddrW{1'b1}} >> l);
  endfunction

endpackage

FILE: rtl/rtlpm_cell.sv
// One slot of the route table chain: holds a route, matches a passing
// transaction token and swaps with a neighbor during compaction. Uses rtlpm_pkg.

module rtlpm_cell #(
  parameter int unsigned CntW   = 7,
  parameter bit          Parity = 1'b0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rtlpm_pkg::ctrl_t      ctrl_i,
  input  logic                  ins_en_i,
  input  rtlpm_pkg::route_t     ins_route_i,
  input  logic                  left_valid_i,
  input  rtlpm_pkg::route_t     left_route_i,
  input  logic                  right_valid_i,
  input  rtlpm_pkg::route_t     right_route_i,
  output logic                  valid_o,
  output rtlpm_pkg::route_t     route_o,
  input  logic                  tok_i,
  input  rtlpm_pkg::acc_t       acc_i,
  input  logic [CntW-1:0]       cnt_i,
  output logic                  tok_o,
  output rtlpm_pkg::acc_t       acc_o,
  output logic [CntW-1:0]       cnt_o
);
  import rtlpm_pkg::*;

  logic             valid_q, valid_d;
  route_t           route_q, route_d;
  logic             tok_q;
  acc_t             acc_q, acc_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] mask;
  logic             match;
  logic             left_role;

  // Compare the held route against the broadcast key
  assign mask  = ctrl_i.is_del ? prefix_mask(ctrl_i.del_len) : prefix_mask(route_q.len);
  assign match = valid_q && (((route_q.prefix ^ ctrl_i.key) & mask) == '0);

  // Pair role for this compaction step
  assign left_role = (Parity == ctrl_i.phase);

  // Slot update: append, kill on delete, swap on compaction
  always_comb begin
    valid_d = valid_q;
    route_d = route_q;
    if (ins_en_i && !valid_q && left_valid_i) begin
      valid_d = 1'b1;
      route_d = ins_route_i;
    end
    if (tok_i && ctrl_i.is_del && match) begin
      valid_d = 1'b0;
    end
    if (ctrl_i.sort_en) begin
      if (left_role) begin
        if (!valid_q && right_valid_i) begin
          valid_d = 1'b1;
          route_d = right_route_i;
        end
      end else begin
        if (valid_q && !left_valid_i) begin
          valid_d = 1'b0;
          route_d = left_route_i;
        end
      end
    end
  end

  // Advance the token accumulator: best match or removal count
  always_comb begin
    acc_d = acc_i;
    cnt_d = cnt_i;
    if (match && !ctrl_i.is_del && (!acc_i.found || (route_q.len > acc_i.len))) begin
      acc_d.found = 1'b1;
      acc_d.len   = route_q.len;
      acc_d.ifx   = route_q.ifx;
      acc_d.hop   = route_q.hop;
    end
    if (match && ctrl_i.is_del) begin
      cnt_d = cnt_i + CntW'(1);
    end
  end

  // Hold control bits under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    route_q <= route_d;
    acc_q   <= acc_d;
    cnt_q   <= cnt_d;
  end

  assign valid_o = valid_q;
  assign route_o = route_q;
  assign tok_o   = tok_q;
  assign acc_o   = acc_q;
  assign cnt_o   = cnt_q;

endmodule

FILE: rtl/route_table_longest_prefix_match.sv
// IPv4 longest-prefix-match route table: top level with sequencer and cell chain.
// Depends on rtlpm_pkg and rtlpm_cell.

// Routes live in a chain of RouteEntries cells, in insertion order from cell 0.
// Insert and an unknown opcode never raise busy: the result strobe done_o comes
// in the cycle after start, so these may be issued every cycle. Lookup sends a
// token down the chain, one cell per cycle, and holds busy until it leaves the
// last cell. Delete walks the chain the same way to drop matches, then closes the
// gaps with RouteEntries odd-even swap steps between neighbor cells while busy.
// Every transaction returns exactly one result, shown for one cycle on done_o;
// the receiver must take it in that cycle.

module route_table_longest_prefix_match #(
  parameter int unsigned RouteEntries = rtlpm_pkg::RouteEntries
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          opcode_i,
  input  logic [rtlpm_pkg::AddrW-1:0]         address_i,
  input  logic [rtlpm_pkg::LenW-1:0]          prefix_len_i,
  input  logic [rtlpm_pkg::IfW-1:0]           if_index_i,
  input  logic [rtlpm_pkg::AddrW-1:0]         next_hop_i,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic [rtlpm_pkg::IfW-1:0]           out_if_index_o,
  output logic [rtlpm_pkg::AddrW-1:0]         out_next_hop_o,
  output logic [rtlpm_pkg::LenW-1:0]          out_prefix_len_o,
  output logic [rtlpm_pkg::RmvW-1:0]          removed_count_o
);
  import rtlpm_pkg::*;

  localparam int unsigned CntW  = $clog2(RouteEntries + 1);
  localparam int unsigned SortW = $clog2(RouteEntries);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_SORT = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic               is_del_q, is_del_d;
  logic [AddrW-1:0]   key_q, key_d;
  logic [LenW-1:0]    del_len_q, del_len_d;
  logic               launch_q, launch_d;
  logic [SortW-1:0]   sort_cnt_q, sort_cnt_d;
  logic [CntW-1:0]    gone_q, gone_d;
  logic               done_q, done_d;
  logic [1:0]         status_q, status_d;
  logic [IfW-1:0]     ifx_q, ifx_d;
  logic [AddrW-1:0]   hop_q, hop_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [RmvW-1:0]    rmv_q, rmv_d;

  logic               accept;
  logic               ins_en;
  route_t             ins_route;
  ctrl_t              ctrl;
  logic [31:0]        gone_ext;

  logic [RouteEntries-1:0] cell_valid;
  logic [RouteEntries-1:0] cell_tok;
  route_t                  cell_route [RouteEntries];
  acc_t                    cell_acc   [RouteEntries];
  logic [CntW-1:0]         cell_cnt   [RouteEntries];

  assign busy   = !state_q[0];
  assign accept = start && !busy;
  assign ins_en = accept && (op_e'(opcode_i) == OP_INSERT);

  assign ins_route.prefix = address_i;
  assign ins_route.len    = clamp_len(prefix_len_i);
  assign ins_route.ifx    = if_index_i;
  assign ins_route.hop    = next_hop_i;

  assign ctrl.is_del  = is_del_q;
  assign ctrl.key     = key_q;
  assign ctrl.del_len = del_len_q;
  assign ctrl.sort_en = (state_q == S_SORT);
  assign ctrl.phase   = sort_cnt_q[0];

  // Build the chain of route cells
  for (genvar i = 0; i < RouteEntries; i++) begin : g_cell
    logic   left_valid, right_valid, tok_in;
    route_t left_route, right_route;
    acc_t   acc_in;
    logic [CntW-1:0] cnt_in;

    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
      assign left_route = '0;
      assign tok_in     = launch_q;
      assign acc_in     = '0;
      assign cnt_in     = '0;
    end else begin : g_body
      assign left_valid = cell_valid[i-1];
      assign left_route = cell_route[i-1];
      assign tok_in     = cell_tok[i-1];
      assign acc_in     = cell_acc[i-1];
      assign cnt_in     = cell_cnt[i-1];
    end

    if (i == RouteEntries - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_route = '0;
    end else begin : g_inner
      assign right_valid = cell_valid[i+1];
      assign right_route = cell_route[i+1];
    end

    rtlpm_cell #(
      .CntW   (CntW),
      .Parity (1'(i % 2))
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .ins_en_i      (ins_en),
      .ins_route_i   (ins_route),
      .left_valid_i  (left_valid),
      .left_route_i  (left_route),
      .right_valid_i (right_valid),
      .right_route_i (right_route),
      .valid_o       (cell_valid[i]),
      .route_o       (cell_route[i]),
      .tok_i         (tok_in),
      .acc_i         (acc_in),
      .cnt_i         (cnt_in),
      .tok_o         (cell_tok[i]),
      .acc_o         (cell_acc[i]),
      .cnt_o         (cell_cnt[i])
    );
  end

  assign gone_ext = 32'(gone_q);

  // Sequence transactions and form the result
  always_comb begin
    state_d    = state_q;
    is_del_d   = is_del_q;
    key_d      = key_q;
    del_len_d  = del_len_q;
    launch_d   = 1'b0;
    sort_cnt_d = sort_cnt_q;
    gone_d     = gone_q;
    done_d     = 1'b0;
    status_d   = status_q;
    ifx_d      = ifx_q;
    hop_d      = hop_q;
    len_d      = len_q;
    rmv_d      = rmv_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ifx_d     = '0;
          hop_d     = '0;
          len_d     = '0;
          rmv_d     = '0;
          key_d     = address_i;
          del_len_d = clamp_len(prefix_len_i);
          unique case (op_e'(opcode_i))
            OP_INSERT: begin
              done_d   = 1'b1;
              status_d = cell_valid[RouteEntries-1] ? ST_FULL : ST_OK;
            end
            OP_LOOKUP: begin
              is_del_d = 1'b0;
              launch_d = 1'b1;
              state_d  = S_WALK;
            end
            OP_DELETE: begin
              is_del_d = 1'b1;
              launch_d = 1'b1;
              state_d  = S_WALK;
            end
            default: begin
              done_d   = 1'b1;
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_WALK: begin
        if (cell_tok[RouteEntries-1]) begin
          if (is_del_q) begin
            gone_d     = cell_cnt[RouteEntries-1];
            sort_cnt_d = '0;
            state_d    = S_SORT;
          end else begin
            done_d   = 1'b1;
            status_d = cell_acc[RouteEntries-1].found ? ST_OK : ST_MISS;
            ifx_d    = cell_acc[RouteEntries-1].ifx;
            hop_d    = cell_acc[RouteEntries-1].hop;
            len_d    = cell_acc[RouteEntries-1].len;
            state_d  = S_IDLE;
          end
        end
      end
      S_SORT: begin
        sort_cnt_d = sort_cnt_q + SortW'(1);
        if (sort_cnt_q == SortW'(RouteEntries - 1)) begin
          done_d   = 1'b1;
          status_d = ST_OK;
          rmv_d    = (gone_ext > 32'(RmvMax)) ? RmvW'(RmvMax) : gone_ext[RmvW-1:0];
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      launch_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      done_q   <= done_d;
    end
  end

  // Operand and result payload
  always_ff @(posedge clk_i) begin
    is_del_q   <= is_del_d;
    key_q      <= key_d;
    del_len_q  <= del_len_d;
    sort_cnt_q <= sort_cnt_d;
    gone_q     <= gone_d;
    status_q   <= status_d;
    ifx_q      <= ifx_d;
    hop_q      <= hop_d;
    len_q      <= len_d;
    rmv_q      <= rmv_d;
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign out_if_index_o   = ifx_q;
  assign out_next_hop_o   = hop_q;
  assign out_prefix_len_o = len_q;
  assign removed_count_o  = rmv_q;

`ifndef ASSERT_OFF
  // Valid slots form an unbroken run from cell 0 whenever the table is idle
  a_no_hole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((cell_valid[RouteEntries-1:1] & ~cell_valid[RouteEntries-2:0]) == '0))
    else $error("route table has a gap between valid slots");

  // A launched token always belongs to a chain walk
  a_launch_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q |-> (state_q == S_WALK))
    else $error("token launched outside a walk");

  // The token leaves the chain only during a walk
  a_tail_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_tok[RouteEntries-1] |-> (state_q == S_WALK))
    else $error("token at chain end outside a walk");

  // A full report means the last slot is occupied
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> cell_valid[RouteEntries-1])
    else $error("table full reported with a free slot");

  // Only one token travels the chain at a time
  a_one_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_tok))
    else $error("more than one token in the chain");
`endif

endmodule

FILE: test/route_table_longest_prefix_match_test.sv
// Self-checking testbench for the route_table_longest_prefix_match route table.
// Depends on rtlpm_pkg and the RTL: drives insert, lookup and delete transactions and
// checks every result against a predictor of the route table held in the testbench.

module route_table_longest_prefix_match_test;

  import rtlpm_pkg::*;

  localparam int unsigned Entries      = RouteEntries;
  localparam int unsigned RandomItems  = 1650;
  localparam int unsigned QuietTail    = 300;
  localparam int unsigned SettleCycles = 2 * Entries + 8;
  localparam int unsigned StallLimit   = 2000;

  // Opcode the block ignores
  localparam logic [1:0] OpIgnored = 2'd3;

  // Expected result of one transaction
  typedef struct packed {
    logic [1:0]       status;
    logic [IfW-1:0]   ifx;
    logic [AddrW-1:0] hop;
    logic [LenW-1:0]  len;
    logic [RmvW-1:0]  removed;
  } route_reply_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [1:0]       opcode_i;
  logic [AddrW-1:0] address_i;
  logic [LenW-1:0]  prefix_len_i;
  logic [IfW-1:0]   if_index_i;
  logic [AddrW-1:0] next_hop_i;
  logic             done_o;
  logic [1:0]       status_o;
  logic [IfW-1:0]   out_if_index_o;
  logic [AddrW-1:0] out_next_hop_o;
  logic [LenW-1:0]  out_prefix_len_o;
  logic [RmvW-1:0]  removed_count_o;

  // Predicted route table, in insertion order from slot 0
  logic [AddrW-1:0] tbl_prefix [Entries];
  logic [LenW-1:0]  tbl_len    [Entries];
  logic [IfW-1:0]   tbl_ifx    [Entries];
  logic [AddrW-1:0] tbl_hop    [Entries];
  int unsigned      tbl_count = 0;

  route_reply_t pending_replies[$];
  int unsigned  mismatch_count = 0;
  int unsigned  stall_cycles = 0;

  always #5 clk_i = ~clk_i;

  route_table_longest_prefix_match dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode_i),
    .address_i        (address_i),
    .prefix_len_i     (prefix_len_i),
    .if_index_i       (if_index_i),
    .next_hop_i       (next_hop_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .out_if_index_o   (out_if_index_o),
    .out_next_hop_o   (out_next_hop_o),
    .out_prefix_len_o (out_prefix_len_o),
    .removed_count_o  (removed_count_o)
  );

  // Mask of the top len bits of an address; len is at most 32
  function automatic logic [AddrW-1:0] route_mask(input logic [LenW-1:0] len);
    if (len == '0) begin
      return '0;
    end
    return {AddrW{1'b1}} << (LenW'(AddrW) - len);
  endfunction

  // Apply one transaction to the predicted table and return its result
  function automatic route_reply_t predict_route_reply(input logic [1:0]       op,
                                                       input logic [AddrW-1:0] addr,
                                                       input logic [LenW-1:0]  len_raw,
                                                       input logic [IfW-1:0]   ifx,
                                                       input logic [AddrW-1:0] hop);
    route_reply_t reply;
    logic [LenW-1:0]  len;
    logic [AddrW-1:0] m;
    int best;
    int unsigned keep;
    int unsigned gone;
    reply = '0;
    len   = (len_raw > LenW'(MaxLen)) ? LenW'(MaxLen) : len_raw;
    best  = -1;
    keep  = 0;
    gone  = 0;
    case (op)
      OP_INSERT: begin
        if (tbl_count >= Entries) begin
          reply.status = ST_FULL;
        end else begin
          tbl_prefix[tbl_count] = addr;
          tbl_len[tbl_count]    = len;
          tbl_ifx[tbl_count]    = ifx;
          tbl_hop[tbl_count]    = hop;
          tbl_count++;
          reply.status = ST_OK;
        end
      end
      OP_LOOKUP: begin
        // Longest length wins; ties keep the earliest slot
        for (int i = 0; i < int'(tbl_count); i++) begin
          m = route_mask(tbl_len[i]);
          if ((((tbl_prefix[i] ^ addr) & m) == '0) &&
              ((best < 0) || (tbl_len[i] > tbl_len[best]))) begin
            best = i;
          end
        end
        if (best < 0) begin
          reply.status = ST_MISS;
        end else begin
          reply.status = ST_OK;
          reply.ifx    = tbl_ifx[best];
          reply.hop    = tbl_hop[best];
          reply.len    = tbl_len[best];
        end
      end
      OP_DELETE: begin
        // Drop matches and shift survivors up, keeping their order
        m = route_mask(len);
        for (int i = 0; i < int'(tbl_count); i++) begin
          if (((tbl_prefix[i] ^ addr) & m) == '0) begin
            gone++;
          end else begin
            tbl_prefix[keep] = tbl_prefix[i];
            tbl_len[keep]    = tbl_len[i];
            tbl_ifx[keep]    = tbl_ifx[i];
            tbl_hop[keep]    = tbl_hop[i];
            keep++;
          end
        end
        tbl_count      = keep;
        reply.status   = ST_OK;
        reply.removed  = (gone > RmvMax) ? RmvW'(RmvMax) : RmvW'(gone);
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  function automatic void check_field(input string name, input logic [AddrW-1:0] want,
                                      input logic [AddrW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Check each result strobe, then predict any transaction taken at this edge
  always @(posedge clk_i) begin : monitor
    route_reply_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: result with no transaction outstanding, status 0x%0h", $time,
                   status_o);
          mismatch_count++;
        end else begin
          want = pending_replies.pop_front();
          check_field("status", AddrW'(want.status), AddrW'(status_o));
          check_field("out_if_index", AddrW'(want.ifx), AddrW'(out_if_index_o));
          check_field("out_next_hop", want.hop, out_next_hop_o);
          check_field("out_prefix_len", AddrW'(want.len), AddrW'(out_prefix_len_o));
          check_field("removed_count", AddrW'(want.removed), AddrW'(removed_count_o));
        end
      end
      if (start && !busy) begin
        pending_replies.push_back(predict_route_reply(opcode_i, address_i, prefix_len_i,
                                                      if_index_i, next_hop_i));
      end
      if ((done_o === 1'b1) || (start && !busy)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // End the run when nothing has moved for too long
  initial begin : watchdog
    @(posedge rst_ni);
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  // Present one transaction and return at the edge that takes it; start stays high
  task automatic issue_route_op(input logic [1:0] op, input logic [AddrW-1:0] addr,
                                input logic [LenW-1:0] len, input logic [IfW-1:0] ifx,
                                input logic [AddrW-1:0] hop);
    start        <= 1'b1;
    opcode_i     <= op;
    address_i    <= addr;
    prefix_len_i <= len;
    if_index_i   <= ifx;
    next_hop_i   <= hop;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Drop start and idle for some cycles
  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drop start and wait until every predicted result has come back
  task automatic wait_for_replies();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [AddrW-1:0] pick_route_addr();
    logic [AddrW-1:0] addr;
    addr = $urandom;
    // Cluster most addresses so prefixes overlap
    if ($urandom_range(0, 3) != 0) begin
      addr[31:24] = 8'd10 + 8'($urandom_range(0, 1));
      addr[23:16] = 8'($urandom_range(0, 3));
    end
    return addr;
  endfunction

  function automatic logic [LenW-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      return '0;
    end else if (r < 15) begin
      return LenW'($urandom_range(33, 63));
    end
    return LenW'($urandom_range(8, 32));
  endfunction

  // Extremes, every operation and the special cases
  task automatic test_directed();
    issue_route_op(OP_LOOKUP, 32'h0000_0000, 6'd0, 8'd0, 32'h0);
    issue_route_op(OP_DELETE, 32'h0000_0000, 6'd0, 8'd0, 32'h0);
    issue_route_op(OpIgnored, 32'hFFFF_FFFF, 6'd63, 8'hFF, 32'hFFFF_FFFF);
    issue_route_op(OP_INSERT, 32'h0A00_0000, 6'd8, 8'd1, 32'h0A00_0001);
    issue_route_op(OP_INSERT, 32'h0A01_0000, 6'd16, 8'd2, 32'h0A01_0001);
    issue_route_op(OP_INSERT, 32'h0A01_0203, 6'd32, 8'hFF, 32'hFFFF_FFFF);
    // Equal length after an earlier route, then an exact duplicate
    issue_route_op(OP_INSERT, 32'h0A01_FFFF, 6'd16, 8'd3, 32'h0A01_0003);
    issue_route_op(OP_INSERT, 32'h0A01_0000, 6'd16, 8'd2, 32'h0A01_0001);
    issue_route_op(OP_LOOKUP, 32'h0A01_0203, 6'd0, 8'd0, 32'h0);
    issue_route_op(OP_LOOKUP, 32'h0A01_0909, 6'd0, 8'd0, 32'h0);
    issue_route_op(OP_LOOKUP, 32'h0AC8_0000, 6'd0, 8'd0, 32'h0);
    issue_route_op(OP_LOOKUP, 32'h0B00_0000, 6'd0, 8'd0, 32'h0);
    // Default route with stray prefix bits
    issue_route_op(OP_INSERT, 32'hFFFF_FFFF, 6'd0, 8'd0, 32'h0000_0000);
    issue_route_op(OP_LOOKUP, 32'h0B00_0000, 6'd0, 8'd0, 32'h0);
    // Lengths above 32 saturate
    issue_route_op(OP_INSERT, 32'hC0A8_0101, 6'd40, 8'd7, 32'hC0A8_0001);
    issue_route_op(OP_INSERT, 32'hC0A8_0102, 6'd63, 8'd8, 32'hC0A8_0002);
    issue_route_op(OP_LOOKUP, 32'hC0A8_0101, 6'd63, 8'hFF, 32'hFFFF_FFFF);
    issue_route_op(OP_LOOKUP, 32'hC0A8_0102, 6'd0, 8'd0, 32'h0);
    issue_route_op(OP_DELETE, 32'h0A01_0000, 6'd16, 8'd0, 32'h0);
    issue_route_op(OP_LOOKUP, 32'h0A01_0203, 6'd0, 8'd0, 32'h0);
    issue_route_op(OP_DELETE, 32'hC0A8_0101, 6'd50, 8'd0, 32'h0);
    issue_route_op(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'd0, 32'h0);
    issue_route_op(OP_DELETE, 32'h1234_5678, 6'd0, 8'd0, 32'h0);
    issue_route_op(OP_LOOKUP, 32'h0A00_0000, 6'd0, 8'd0, 32'h0);
  endtask

  // Fill every slot, overflow, then free one slot and refill it
  task automatic test_table_full();
    issue_route_op(OP_DELETE, 32'h0, 6'd0, 8'd0, 32'h0);
    for (int i = 0; i < int'(Entries); i++) begin
      issue_route_op(OP_INSERT, {8'd10, 8'(i), 16'($urandom)}, LenW'($urandom_range(16, 32)),
                     8'($urandom), $urandom);
    end
    issue_route_op(OP_INSERT, $urandom, 6'd24, 8'd9, $urandom);
    issue_route_op(OP_INSERT, 32'hFFFF_FFFF, 6'd32, 8'hFF, 32'hFFFF_FFFF);
    issue_route_op(OP_LOOKUP, {8'd10, 8'd5, 16'($urandom)}, 6'd0, 8'd0, 32'h0);
    issue_route_op(OP_LOOKUP, {8'd10, 8'd63, 16'($urandom)}, 6'd0, 8'd0, 32'h0);
    issue_route_op(OpIgnored, $urandom, 6'($urandom), 8'($urandom), $urandom);
    issue_route_op(OP_DELETE, {8'd10, 8'd5, 16'h0}, 6'd16, 8'd0, 32'h0);
    issue_route_op(OP_INSERT, 32'h0A05_0000, 6'd16, 8'd55, 32'h0505_0505);
    issue_route_op(OP_INSERT, 32'h0A06_0000, 6'd16, 8'd66, 32'h0606_0606);
    issue_route_op(OP_LOOKUP, 32'h0A05_1234, 6'd0, 8'd0, 32'h0);
    issue_route_op(OP_DELETE, 32'h0, 6'd0, 8'd0, 32'h0);
  endtask

  // Let the block go idle before each transaction
  task automatic test_idle_sender();
    wait_for_replies();
    issue_route_op(OP_INSERT, 32'h0A00_0000, 6'd8, 8'd4, 32'h0A00_00FE);
    wait_for_replies();
    issue_route_op(OP_LOOKUP, 32'h0A7F_0001, 6'd0, 8'd0, 32'h0);
    wait_for_replies();
    issue_route_op(OP_DELETE, 32'h0A00_0000, 6'd8, 8'd0, 32'h0);
    wait_for_replies();
  endtask

  // Mixed traffic with phases of heavy and light insertion
  task automatic test_random_traffic();
    int unsigned insert_weight;
    int unsigned r;
    int unsigned slot;
    logic [1:0]       op;
    logic [AddrW-1:0] addr;
    logic [LenW-1:0]  len;
    logic [AddrW-1:0] m;
    insert_weight = 50;
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if ((i % 200) == 0) begin
        insert_weight = $urandom_range(35, 75);
      end
      r    = $urandom_range(0, 99);
      addr = pick_route_addr();
      len  = pick_len();
      if (r < 3) begin
        op = OpIgnored;
      end else if (r < 3 + insert_weight) begin
        op = OP_INSERT;
      end else if (r < 3 + insert_weight + (97 - insert_weight) * 2 / 3) begin
        op = OP_LOOKUP;
        // Aim mostly at stored routes with random host bits
        if ((tbl_count > 0) && ($urandom_range(0, 9) < 7)) begin
          slot = $urandom_range(0, tbl_count - 1);
          m    = route_mask(tbl_len[slot]);
          addr = (tbl_prefix[slot] & m) | ($urandom & ~m);
        end
        len = 6'($urandom);
      end else begin
        op = OP_DELETE;
        // Mostly narrow deletes of stored routes, a few wide ones
        if ((tbl_count > 0) && ($urandom_range(0, 9) < 7)) begin
          slot = $urandom_range(0, tbl_count - 1);
          addr = tbl_prefix[slot];
          len  = ($urandom_range(0, 4) != 0) ? LenW'($urandom_range(24, 63))
                                             : LenW'($urandom_range(0, 23));
        end else begin
          len = 6'($urandom);
        end
      end
      issue_route_op(op, addr, len, 8'($urandom), $urandom);
      if (i < RandomItems - QuietTail) begin
        if ($urandom_range(0, 99) == 0) begin
          wait_for_replies();
        end else if ($urandom_range(0, 7) == 0) begin
          hold_off($urandom_range(1, 18));
        end
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    opcode_i     = OP_INSERT;
    address_i    = '0;
    prefix_len_i = '0;
    if_index_i   = '0;
    next_hop_i   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_table_full();
    test_idle_sender();
    test_random_traffic();

    // Drain, then give the block time to show any stray result
    wait_for_replies();
    repeat (SettleCycles) @(posedge clk_i);
    if ((mismatch_count == 0) && (pending_replies.size() == 0)) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
